>>> design/sbs_pkg.sv
// Package for the substring search block: sizes, register codes, config struct
// and the case-fold helper. No dependencies.
package sbs_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 64;
    localparam int PATTERN_BITS    = 2 * CFG_DATA_BITS;
    localparam int LEN_BITS        = 5;
    localparam int LIMIT_BITS      = 16;
    localparam int OFFSET_BITS     = 16;
    localparam int BYTE_BITS       = 8;

    localparam logic [LEN_BITS-1:0]   LEN_RESET   = LEN_BITS'(1);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = {LIMIT_BITS{1'b1}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_PATTERN_LENGTH = 3'd2,
        REG_CASE_FOLD      = 3'd3,
        REG_TEXT_LIMIT     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [PATTERN_BITS-1:0] pattern;
        logic [LEN_BITS-1:0]     length;
        logic                    case_fold;
        logic [LIMIT_BITS-1:0]   text_limit;
    } cfg_t;

    // lower-case ASCII letters map onto upper case when folding is on
    function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] c,
                                                       input logic en);
        logic [BYTE_BITS-1:0] r;
        r = c;
        if (en && c >= 8'h61 && c <= 8'h7a)
            r = c - 8'h20;
        return r;
    endfunction

endpackage

>>> design/substring_search.sv
// Substring search top level: config port, input word register, window state
// and result register. Depends on sbs_pkg, sbs_cfg and sbs_match.
// The accepted byte goes into the input word register; the result register loads
// from it when the input word moves on, which an output stall can hold back.
// Throughput: one text byte per cycle while the output does not stall, set by the
// window and byte count update; output stalls hold the input register.
// Reset: asynchronous active-low; config returns to its reset values, window,
// byte count and done flag clear at once, no clearing pass.
module substring_search
    import sbs_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [BYTE_BITS-1:0]      text_byte,
    input  logic                      is_last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic [OFFSET_BITS-1:0]    match_offset
);

    localparam int LW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_BITS{1'b1}});

    cfg_t cfg;

    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 in_last_reg;

    logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] window_reg, window_next, window_shift;
    logic [COUNT_BITS-1:0] byte_count_reg, byte_count_next, count_inc;
    logic                  finished_reg, finished_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;

    logic                   proc_fire, emit, searchable, hit;
    logic [LW-1:0]          limit;
    logic [OFFSET_BITS-1:0] hit_offset;

    assign cfg_ready = 1'b1;

    sbs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sbs_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_match (
        .window (window_shift),
        .count  (count_inc),
        .cfg    (cfg),
        .hit    (hit),
        .offset (hit_offset)
    );

    // the input word moves on when the result register can take a new word
    assign proc_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        window_shift[0] = in_byte_reg;
        for (int k = 1; k < MAX_PATTERN; k++)
            window_shift[k] = window_reg[k-1];
    end

    assign count_inc  = byte_count_reg + COUNT_BITS'(1);
    assign limit      = (LW'(cfg.text_limit) < CNT_MAX) ? LW'(cfg.text_limit) : CNT_MAX;
    assign searchable = (in_byte_reg != '0) && (LW'(byte_count_reg) < limit);

    always_comb
    begin
        window_next     = window_reg;
        byte_count_next = byte_count_reg;
        emit            = 1'b0;
        found_next      = 1'b0;
        offset_next     = '0;
        if (proc_fire && !finished_reg)
        begin
            if (searchable)
            begin
                window_next     = window_shift;
                byte_count_next = count_inc;
                if (hit)
                begin
                    emit        = 1'b1;
                    found_next  = 1'b1;
                    offset_next = hit_offset;
                end
                else if (LW'(count_inc) >= limit || in_last_reg)
                begin
                    emit = 1'b1;
                end
            end
            else
            begin
                // NUL byte or past the limit ends the text unmatched
                emit = 1'b1;
            end
        end
        finished_next = finished_reg || emit;
        if (proc_fire && in_last_reg)
        begin
            window_next     = '0;
            byte_count_next = '0;
            finished_next   = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            window_reg     <= '0;
            byte_count_reg <= '0;
            finished_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            window_reg     <= window_next;
            byte_count_reg <= byte_count_next;
            finished_reg   <= finished_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= text_byte;
            in_last_reg <= is_last;
        end
        if (emit)
        begin
            found_reg  <= found_next;
            offset_reg <= offset_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

    // one result per text
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !finished_reg)
        else $error("second result for one text");

    // the last word of a text always leaves a clean state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_last_reg |=> byte_count_reg == '0 && !finished_reg)
        else $error("state not cleared after last word");

    // a result is never dropped by a new one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !emit)
        else $error("result overwritten while stalled");

    // a stalled input word stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc_fire |=> in_valid_reg && $stable(in_byte_reg)
                                       && $stable(in_last_reg))
        else $error("input word lost while stalled");

    // a text never gets past its last word without a result
    a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_last_reg |-> finished_reg || emit)
        else $error("text ended without a result");

endmodule

>>> design/sbs_cfg.sv
// Configuration register file of the substring search block.
// Depends on sbs_pkg.
module sbs_cfg
    import sbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_PATTERN_LOW:    cfg_next.pattern[CFG_DATA_BITS-1:0] = wr_data;
                REG_PATTERN_HIGH:
                    cfg_next.pattern[PATTERN_BITS-1:CFG_DATA_BITS] = wr_data;
                REG_PATTERN_LENGTH: cfg_next.length = wr_data[LEN_BITS-1:0];
                REG_CASE_FOLD:      cfg_next.case_fold = wr_data[0];
                REG_TEXT_LIMIT:     cfg_next.text_limit = wr_data[LIMIT_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern    <= '0;
            cfg_reg.length     <= LEN_RESET;
            cfg_reg.case_fold  <= 1'b0;
            cfg_reg.text_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/sbs_match.sv
// Parallel window compare: checks the newest bytes against the pattern and
// forms the start offset. Depends on sbs_pkg.
module sbs_match
    import sbs_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] window,  // newest first
    input  logic [COUNT_BITS-1:0]                 count,   // after this byte
    input  cfg_t                                  cfg,
    output logic                                  hit,
    output logic [OFFSET_BITS-1:0]                offset
);

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = (COUNT_BITS > OFFSET_BITS) ? COUNT_BITS : OFFSET_BITS;
    localparam logic [LEN_BITS-1:0] MP_LEN = LEN_BITS'(MAX_PATTERN);

    logic [LEN_BITS-1:0]    len;
    logic [MAX_PATTERN-1:0] eq;
    logic [LW-1:0]          diff;

    assign len = (cfg.length > MP_LEN) ? MP_LEN : cfg.length;

    // pattern byte i lines up with window entry len-1-i
    always_comb
    begin
        logic [LEN_BITS-1:0] idx;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            idx = len - LEN_BITS'(1) - LEN_BITS'(i);
            if (LEN_BITS'(i) < len)
                eq[i] = fold_byte(window[idx[IW-1:0]], cfg.case_fold) ==
                        fold_byte(cfg.pattern[i*BYTE_BITS +: BYTE_BITS], cfg.case_fold);
            else
                eq[i] = 1'b1;
        end
    end

    assign hit    = (len != '0) && (LW'(count) >= LW'(len)) && (&eq);
    assign diff   = LW'(count) - LW'(len);
    assign offset = diff[OFFSET_BITS-1:0];

endmodule
